// File: hdl/ber_tlv_header_parser_unit_assert.svh
// Assertion macros for the BER TLV header parser.
// Used by ber_tlv_header_parser_unit.sv; define ASSERT_OFF to compile them out.
`ifndef BER_TLV_HEADER_PARSER_UNIT_ASSERT_SVH
`define BER_TLV_HEADER_PARSER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define BTP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BTP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hdl/btp_pkg.sv
// Package for the BER TLV header parser: parse phases, codes and field widths.
// No dependencies; used by ber_tlv_header_parser_unit.
package btp_pkg;

   localparam int MAX_LENGTH_BYTES = 4;
   localparam int VALUE_WIDTH      = 32;
   localparam int LENGTH_WIDTH     = 32;
   localparam int LBYTES_WIDTH     = 7;

   typedef enum logic [1:0] {
      PH_ID   = 2'd0,
      PH_LEN1 = 2'd1,
      PH_LENN = 2'd2,
      PH_BODY = 2'd3
   } phase_type;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_BOOL  = 2'd1;
   localparam logic [1:0] KIND_INT   = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_LEN_OVER = 2'd1;
   localparam logic [1:0] ST_INT_OVER = 2'd2;

   localparam logic [4:0] TAG_BOOLEAN    = 5'd1;
   localparam logic [4:0] TAG_INTEGER    = 5'd2;
   localparam logic [4:0] TAG_ENUMERATED = 5'd10;

   function automatic logic [1:0] kind_of(input logic [4:0] tag);
      logic [1:0] kind;
      kind = KIND_OTHER;
      if (tag == TAG_BOOLEAN) begin
         kind = KIND_BOOL;
      end else if (tag == TAG_INTEGER || tag == TAG_ENUMERATED) begin
         kind = KIND_INT;
      end
      return kind;
   endfunction

endpackage

// File: hdl/ber_tlv_header_parser_unit.sv
// BER TLV header parser top level: byte-wide parser registers and a result register.
// Depends on btp_pkg and ber_tlv_header_parser_unit_assert.svh.

// Takes one BER byte per cycle on the req_ channel and returns one word on the
// rsp_ channel for each completed identifier/length/content triple. Every byte
// is handled in the cycle it is accepted: the parser registers update with a
// byte shift-in and the result, if any, lands in the output register, so the
// block sustains one byte per cycle while rsp_ready is high. req_ready drops
// only while a finished result is held and not taken. req_frame_start forces
// the byte to be read as a new identifier, dropping any partial TLV. Length
// fields over four bytes are consumed and flagged (status 1); integer content
// over four bytes keeps its low 32 bits and is flagged (status 2). The
// indefinite length form counts as length zero; the high-tag form is not decoded.
module ber_tlv_header_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_tag_class,
   output logic        rsp_constructed,
   output logic [4:0]  rsp_tag_number,
   output logic [31:0] rsp_content_length,
   output logic [1:0]  rsp_value_kind,
   output logic [31:0] rsp_int_value,
   output logic        rsp_bool_value,
   output logic [1:0]  rsp_status
);

   btp_pkg::phase_type                      phase_ff, phase_in;
   logic [7:0]                              ident_ff, ident_in;
   logic [btp_pkg::LBYTES_WIDTH-1:0]        lbytes_ff, lbytes_in;
   logic [btp_pkg::LENGTH_WIDTH-1:0]        length_ff, length_in;
   logic [btp_pkg::LENGTH_WIDTH-1:0]        content_ff, content_in;
   logic [btp_pkg::VALUE_WIDTH-1:0]         value_ff, value_in;
   logic                                    seen_ff, seen_in;
   logic                                    bool_ff, bool_in;
   logic [1:0]                              error_ff, error_in;

   logic                                    rsp_valid_ff;
   logic [7:0]                              out_ident_ff;
   logic [btp_pkg::LENGTH_WIDTH-1:0]        out_length_ff;
   logic [1:0]                              out_kind_ff;
   logic [31:0]                             out_int_ff;
   logic                                    out_bool_ff;
   logic [1:0]                              out_status_ff;

   logic                                    req_fire;
   logic                                    emit;
   logic [1:0]                              kind;
   logic [1:0]                              status;
   logic [btp_pkg::LBYTES_WIDTH-1:0]        lbytes_dec;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign lbytes_dec = lbytes_ff - btp_pkg::LBYTES_WIDTH'(1);

   always_comb begin
      phase_in   = phase_ff;
      ident_in   = ident_ff;
      lbytes_in  = lbytes_ff;
      length_in  = length_ff;
      content_in = content_ff;
      value_in   = value_ff;
      seen_in    = seen_ff;
      bool_in    = bool_ff;
      error_in   = error_ff;
      emit       = 1'b0;
      if (req_frame_start || phase_ff == btp_pkg::PH_ID) begin
         ident_in   = req_data_byte;
         lbytes_in  = '0;
         length_in  = '0;
         content_in = '0;
         value_in   = '0;
         seen_in    = 1'b0;
         bool_in    = 1'b0;
         error_in   = btp_pkg::ST_OK;
         phase_in   = btp_pkg::PH_LEN1;
      end else begin
         case (phase_ff)
            btp_pkg::PH_LEN1: begin
               if (!req_data_byte[7]) begin
                  length_in = btp_pkg::LENGTH_WIDTH'(req_data_byte);
                  if (req_data_byte == 8'd0) begin
                     emit = 1'b1;
                  end else begin
                     content_in = btp_pkg::LENGTH_WIDTH'(req_data_byte);
                     phase_in   = btp_pkg::PH_BODY;
                  end
               end else begin
                  lbytes_in = req_data_byte[6:0];
                  length_in = '0;
                  if (req_data_byte[6:0] > btp_pkg::LBYTES_WIDTH'(btp_pkg::MAX_LENGTH_BYTES)) begin
                     error_in = btp_pkg::ST_LEN_OVER;
                  end
                  if (req_data_byte[6:0] == '0) begin
                     emit = 1'b1;
                  end else begin
                     phase_in = btp_pkg::PH_LENN;
                  end
               end
            end
            btp_pkg::PH_LENN: begin
               length_in = {length_ff[btp_pkg::LENGTH_WIDTH-9:0], req_data_byte};
               lbytes_in = lbytes_dec;
               if (lbytes_dec == '0) begin
                  if (length_in == '0) begin
                     emit = 1'b1;
                  end else begin
                     content_in = length_in;
                     phase_in   = btp_pkg::PH_BODY;
                  end
               end
            end
            btp_pkg::PH_BODY: begin
               value_in   = {value_ff[btp_pkg::VALUE_WIDTH-9:0], req_data_byte};
               content_in = content_ff - btp_pkg::LENGTH_WIDTH'(1);
               if (!seen_ff) begin
                  seen_in = 1'b1;
                  bool_in = (req_data_byte != 8'd0);
               end
               if (content_in == '0) begin
                  emit = 1'b1;
               end
            end
            default: begin
               phase_in = btp_pkg::PH_ID;
            end
         endcase
      end
      if (emit) begin
         phase_in = btp_pkg::PH_ID;
      end
   end

   always_comb begin
      kind   = btp_pkg::kind_of(ident_ff[4:0]);
      status = error_in;
      if (kind == btp_pkg::KIND_INT && error_in == btp_pkg::ST_OK &&
          length_in > btp_pkg::LENGTH_WIDTH'(btp_pkg::VALUE_WIDTH / 8)) begin
         status = btp_pkg::ST_INT_OVER;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= btp_pkg::PH_ID;
         ident_ff   <= '0;
         lbytes_ff  <= '0;
         length_ff  <= '0;
         content_ff <= '0;
         value_ff   <= '0;
         seen_ff    <= 1'b0;
         bool_ff    <= 1'b0;
         error_ff   <= btp_pkg::ST_OK;
      end else if (req_fire) begin
         phase_ff   <= phase_in;
         ident_ff   <= ident_in;
         lbytes_ff  <= lbytes_in;
         length_ff  <= length_in;
         content_ff <= content_in;
         value_ff   <= value_in;
         seen_ff    <= seen_in;
         bool_ff    <= bool_in;
         error_ff   <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the result word until taken; req_ready keeps a new one from landing early
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         out_ident_ff  <= ident_ff;
         out_length_ff <= length_in;
         out_kind_ff   <= kind;
         out_int_ff    <= (kind == btp_pkg::KIND_INT) ? 32'(value_in) : 32'd0;
         out_bool_ff   <= (kind == btp_pkg::KIND_BOOL) ? bool_in : 1'b0;
         out_status_ff <= status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_tag_class      = out_ident_ff[7:6];
   assign rsp_constructed    = out_ident_ff[5];
   assign rsp_tag_number     = out_ident_ff[4:0];
   assign rsp_content_length = out_length_ff;
   assign rsp_value_kind     = out_kind_ff;
   assign rsp_int_value      = out_int_ff;
   assign rsp_bool_value     = out_bool_ff;
   assign rsp_status         = out_status_ff;

`include "ber_tlv_header_parser_unit_assert.svh"

   `BTP_ASSERT_NEXT(a_frame_start_restarts, clock, reset, req_fire && req_frame_start, phase_ff == btp_pkg::PH_LEN1, "frame start did not restart the parse")
   `BTP_ASSERT_IMPL(a_int_zero_if_not_int, clock, reset, rsp_valid && rsp_value_kind != btp_pkg::KIND_INT, rsp_int_value == 32'd0, "integer value set on a non-integer tag")
   `BTP_ASSERT_IMPL(a_bool_zero_if_not_bool, clock, reset, rsp_valid && rsp_value_kind != btp_pkg::KIND_BOOL, !rsp_bool_value, "boolean set on a non-boolean tag")
   `BTP_ASSERT_IMPL(a_int_over_consistent, clock, reset, rsp_valid && rsp_status == btp_pkg::ST_INT_OVER, rsp_value_kind == btp_pkg::KIND_INT && rsp_content_length > 32'd4, "integer overflow flag without long integer")
   `BTP_ASSERT_NEXT(a_emit_returns_to_id, clock, reset, req_fire && emit, phase_ff == btp_pkg::PH_ID && rsp_valid, "result issued without returning to identifier phase")

endmodule
